// ----- rtl/assert_macros.svh -----
// assertion macros shared by the scheduler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RRTS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge out of reset
`define RRTS_ASSERT_NEVER(name, cond, msg) \
    `RRTS_ASSERT(name, !(cond), msg)

`endif

// ----- rtl/rrts_pkg.sv -----
// shared types, codes and constants of the round-robin task scheduler
`timescale 1ns / 1ps

package rrts_pkg;

    // default size of the task table
    localparam int MAX_TASKS_DEF = 16;

    // field widths
    localparam int ACTION_W  = 3;
    localparam int SLOT_IN_W = 4;
    localparam int RC_W      = 2;
    localparam int ST_W      = 3;

    // actions
    localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_YIELD  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_BLOCK  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_WAKE   = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_KILL   = 3'd6;

    // result codes
    localparam logic [RC_W-1:0] RC_OK         = 2'd0;
    localparam logic [RC_W-1:0] RC_NOFREE     = 2'd1;
    localparam logic [RC_W-1:0] RC_NOTSTARTED = 2'd2;
    localparam logic [RC_W-1:0] RC_BADSLOT    = 2'd3;

    // slot states
    localparam logic [ST_W-1:0] SS_EMPTY   = 3'd0;
    localparam logic [ST_W-1:0] SS_READY   = 3'd1;
    localparam logic [ST_W-1:0] SS_RUNNING = 3'd2;
    localparam logic [ST_W-1:0] SS_BLOCKED = 3'd3;
    localparam logic [ST_W-1:0] SS_DEAD    = 3'd4;

    // write controls from the sequencer to the task table
    typedef struct packed {
        logic            st_we;
        logic [ST_W-1:0] st_wdata;
        logic            nx_we;
    } t_tbl_ctl;

    // one result beat
    typedef struct packed {
        logic [RC_W-1:0]      rc;
        logic [SLOT_IN_W-1:0] cur;
        logic                 idle;
        logic [SLOT_IN_W-1:0] new_slot;
    } t_rslt;

endpackage

// ----- rtl/rrts_table.sv -----
// task table: slot state memory with valid bits and ring link memory
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrts_table
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  t_tbl_ctl                                           i_ctl,
    input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] i_raddr,
    input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] i_st_waddr,
    input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] i_nx_waddr,
    input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] i_nx_wdata,
    output logic [ST_W-1:0]                                    o_st,
    output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] o_nx
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic [ST_W-1:0]   r_st_mem [MAX_TASKS];
    logic [SLOT_W-1:0] r_nx_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_vld;

    logic [ST_W-1:0]   r_st_q;
    logic [SLOT_W-1:0] r_nx_q;
    logic              r_vld_q;

    logic st_hit;
    logic nx_hit;

    // same-cycle write to the read address is forwarded
    assign st_hit = i_ctl.st_we && (i_st_waddr == i_raddr);
    assign nx_hit = i_ctl.nx_we && (i_nx_waddr == i_raddr);

    // slot state memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.st_we) begin
            r_st_mem[i_st_waddr] <= i_ctl.st_wdata;
        end
        r_st_q <= st_hit ? i_ctl.st_wdata : r_st_mem[i_raddr];
    end

    // ring link memory, entries read only after being linked
    always_ff @(posedge i_clk) begin
        if (i_ctl.nx_we) begin
            r_nx_mem[i_nx_waddr] <= i_nx_wdata;
        end
        r_nx_q <= nx_hit ? i_nx_wdata : r_nx_mem[i_raddr];
    end

    // per-slot valid bits, a never-written slot reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_ctl.st_we) begin
                r_vld[i_st_waddr] <= 1'b1;
            end
            r_vld_q <= r_vld[i_raddr] | st_hit;
        end
    end

    assign o_st = r_vld_q ? r_st_q : SS_EMPTY;
    assign o_nx = r_nx_q;

    `RRTS_ASSERT(a_st_fwd, st_hit |=> (o_st == $past(i_ctl.st_wdata)), "state forward lost")

endmodule

// ----- rtl/rrts_ctrl.sv -----
// action sequencer: walks the ring through the task table one slot a cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrts_ctrl
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_valid,
    output logic                                               o_ready,
    input  logic [ACTION_W-1:0]                                i_action,
    input  logic [SLOT_IN_W-1:0]                               i_slot,
    output t_tbl_ctl                                           o_ctl,
    output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] o_raddr,
    output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] o_st_waddr,
    output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] o_nx_waddr,
    output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] o_nx_wdata,
    input  logic [ST_W-1:0]                                    i_st,
    input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] i_nx,
    output logic                                               o_done,
    input  logic                                               i_ack,
    output t_rslt                                              o_rslt
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_CRT_SCAN = 4'd2;
    localparam logic [3:0] S_CRT_LINK = 4'd3;
    localparam logic [3:0] S_SWEEP    = 4'd4;
    localparam logic [3:0] S_CLOSE    = 4'd5;
    localparam logic [3:0] S_SEEK     = 4'd6;
    localparam logic [3:0] S_SRCH     = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [ACTION_W-1:0]  r_action, n_action;
    logic [SLOT_IN_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0]    r_ra;
    logic [SLOT_W-1:0]    r_head, n_head;
    logic [SLOT_W-1:0]    r_tail, n_tail;
    logic                 r_occ, n_occ;
    logic [SLOT_W-1:0]    r_run, n_run;
    logic                 r_started, n_started;
    logic                 r_idle, n_idle;
    logic [RC_W-1:0]      r_rc, n_rc;
    logic [SLOT_W-1:0]    r_new, n_new;
    logic [SLOT_W-1:0]    r_first, n_first;
    logic [SLOT_W-1:0]    r_prev, n_prev;
    logic                 r_kept, n_kept;
    logic [SLOT_W-1:0]    r_s0, n_s0;

    logic                 in_bad;
    logic                 wake_bad;
    logic [SLOT_W-1:0]    scan_next;

    // slot numbers beyond the table
    assign in_bad    = 32'(i_slot) >= 32'(MAX_TASKS);
    assign wake_bad  = 32'(r_slot) >= 32'(MAX_TASKS);
    assign scan_next = (r_ra == LAST_SLOT) ? '0 : r_ra + SLOT_W'(1);

    // sequencer next state and table access
    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_slot    = r_slot;
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_run     = r_run;
        n_started = r_started;
        n_idle    = r_idle;
        n_rc      = r_rc;
        n_new     = r_new;
        n_first   = r_first;
        n_prev    = r_prev;
        n_kept    = r_kept;
        n_s0      = r_s0;

        o_ctl        = '0;
        o_raddr      = r_ra;
        o_st_waddr   = '0;
        o_nx_waddr   = '0;
        o_nx_wdata   = '0;
        o_ready      = 1'b0;
        o_done       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                // fetch the entry the incoming action needs first
                unique case (i_action)
                    ACT_CREATE: o_raddr = '0;
                    ACT_START:  o_raddr = r_head;
                    ACT_WAKE:   o_raddr = in_bad ? '0 : SLOT_W'(i_slot);
                    default:    o_raddr = r_run;
                endcase
                if (i_valid) begin
                    n_action = i_action;
                    n_slot   = i_slot;
                    n_rc     = RC_OK;
                    n_new    = '0;
                    n_state  = (i_action == ACT_CREATE) ? S_CRT_SCAN : S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_action)
                    ACT_START: begin
                        if (!r_started) begin
                            if (!r_occ) begin
                                n_rc = RC_NOTSTARTED;
                            end else begin
                                n_started      = 1'b1;
                                n_idle         = 1'b0;
                                n_run          = r_head;
                                o_ctl.st_we    = 1'b1;
                                o_ctl.st_wdata = SS_RUNNING;
                                o_st_waddr     = r_head;
                            end
                        end
                    end
                    ACT_TICK: begin
                        if (!r_started) begin
                            n_rc = RC_NOTSTARTED;
                        end else begin
                            // running current task goes back to ready
                            if (!r_idle && i_st == SS_RUNNING) begin
                                o_ctl.st_we    = 1'b1;
                                o_ctl.st_wdata = SS_READY;
                                o_st_waddr     = r_run;
                            end
                            if (r_occ) begin
                                o_raddr = r_head;
                                n_kept  = 1'b0;
                                n_state = S_SWEEP;
                            end else begin
                                n_idle = 1'b1;
                                n_run  = '0;
                            end
                        end
                    end
                    ACT_YIELD: begin
                        if (!r_started) begin
                            n_rc = RC_NOTSTARTED;
                        end else if (r_idle) begin
                            if (!r_occ) begin
                                n_rc = RC_NOTSTARTED;
                            end else begin
                                n_run  = r_head;
                                n_idle = 1'b0;
                            end
                        end else begin
                            n_run = i_nx;
                        end
                    end
                    ACT_BLOCK: begin
                        if (!r_started) begin
                            n_rc = RC_NOTSTARTED;
                        end else if (!r_idle && i_st == SS_RUNNING) begin
                            o_ctl.st_we    = 1'b1;
                            o_ctl.st_wdata = SS_BLOCKED;
                            o_st_waddr     = r_run;
                        end
                    end
                    ACT_WAKE: begin
                        if (wake_bad || i_st == SS_EMPTY) begin
                            n_rc = RC_BADSLOT;
                        end else if (i_st == SS_BLOCKED) begin
                            o_ctl.st_we    = 1'b1;
                            o_ctl.st_wdata = SS_READY;
                            o_st_waddr     = SLOT_W'(r_slot);
                        end
                    end
                    ACT_KILL: begin
                        if (!r_started) begin
                            n_rc = RC_NOTSTARTED;
                        end else if (!r_idle) begin
                            o_ctl.st_we    = 1'b1;
                            o_ctl.st_wdata = SS_DEAD;
                            o_st_waddr     = r_run;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // lowest empty slot, one slot per cycle
            S_CRT_SCAN: begin
                o_raddr = scan_next;
                if (i_st == SS_EMPTY) begin
                    o_ctl.st_we    = 1'b1;
                    o_ctl.st_wdata = SS_READY;
                    o_st_waddr     = r_ra;
                    n_new          = r_ra;
                    n_tail         = r_ra;
                    o_ctl.nx_we    = 1'b1;
                    if (r_occ) begin
                        o_nx_waddr = r_tail;
                        o_nx_wdata = r_ra;
                        n_state    = S_CRT_LINK;
                    end else begin
                        o_nx_waddr = r_ra;
                        o_nx_wdata = r_ra;
                        n_head     = r_ra;
                        n_occ      = 1'b1;
                        n_state    = S_DONE;
                    end
                end else if (r_ra == LAST_SLOT) begin
                    n_rc    = RC_NOFREE;
                    n_state = S_DONE;
                end
            end

            // close the ring behind the new tail
            S_CRT_LINK: begin
                o_ctl.nx_we = 1'b1;
                o_nx_waddr  = r_new;
                o_nx_wdata  = r_head;
                n_state     = S_DONE;
            end

            // walk from the head, free dead tasks (sparing the current one unless idle runs) and relink the survivors
            S_SWEEP: begin
                if (i_st == SS_DEAD && (r_idle || r_ra != r_run)) begin
                    o_ctl.st_we    = 1'b1;
                    o_ctl.st_wdata = SS_EMPTY;
                    o_st_waddr     = r_ra;
                end else begin
                    if (r_kept) begin
                        o_ctl.nx_we = 1'b1;
                        o_nx_waddr  = r_prev;
                        o_nx_wdata  = r_ra;
                    end else begin
                        n_first = r_ra;
                    end
                    n_prev = r_ra;
                    n_kept = 1'b1;
                end
                if (i_nx == r_head) begin
                    n_state = S_CLOSE;
                end else begin
                    o_raddr = i_nx;
                end
            end

            // link last survivor to first and pick the search start, or empty the ring when none survive
            S_CLOSE: begin
                if (r_kept) begin
                    o_ctl.nx_we = 1'b1;
                    o_nx_waddr  = r_prev;
                    o_nx_wdata  = r_first;
                    n_head      = r_first;
                    n_tail      = r_prev;
                    if (r_idle) begin
                        o_raddr = r_first;
                        n_s0    = r_first;
                        n_state = S_SRCH;
                    end else begin
                        o_raddr = r_run;
                        n_state = S_SEEK;
                    end
                end else begin
                    n_occ   = 1'b0;
                    n_head  = '0;
                    n_tail  = '0;
                    n_idle  = 1'b1;
                    n_run   = '0;
                    n_state = S_DONE;
                end
            end

            // step past the current task
            S_SEEK: begin
                o_raddr = i_nx;
                n_s0    = i_nx;
                n_state = S_SRCH;
            end

            // once round the ring to the first ready task
            S_SRCH: begin
                if (i_st == SS_READY) begin
                    o_ctl.st_we    = 1'b1;
                    o_ctl.st_wdata = SS_RUNNING;
                    o_st_waddr     = r_ra;
                    n_run          = r_ra;
                    n_idle         = 1'b0;
                    n_state        = S_DONE;
                end else if (i_nx == r_s0) begin
                    n_idle  = 1'b1;
                    n_run   = '0;
                    n_state = S_DONE;
                end else begin
                    o_raddr = i_nx;
                end
            end

            S_DONE: begin
                o_done = 1'b1;
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= 1'b0;
            r_run     <= '0;
            r_started <= 1'b0;
            r_idle    <= 1'b0;
            r_kept    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_occ     <= n_occ;
            r_run     <= n_run;
            r_started <= n_started;
            r_idle    <= n_idle;
            r_kept    <= n_kept;
        end
    end

    // per-action working registers
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_slot   <= n_slot;
        r_ra     <= o_raddr;
        r_rc     <= n_rc;
        r_new    <= n_new;
        r_first  <= n_first;
        r_prev   <= n_prev;
        r_s0     <= n_s0;
    end

    // result beat
    always_comb begin
        o_rslt.rc       = r_rc;
        o_rslt.cur      = r_idle ? '0 : SLOT_IN_W'(r_run);
        o_rslt.idle     = r_idle;
        o_rslt.new_slot = SLOT_IN_W'(r_new);
    end

    `RRTS_ASSERT(a_idle_started, r_idle |-> r_started, "idle task runs before start")
    `RRTS_ASSERT(a_idle_slot, r_idle |-> (r_run == '0), "idle with nonzero slot")
    `RRTS_ASSERT(a_empty_ring, !r_occ |-> (r_head == '0 && r_tail == '0), "empty ring ends")
    `RRTS_ASSERT_NEVER(a_sweep_link, r_state == S_SWEEP && o_ctl.nx_we && o_nx_waddr == r_ra, "sweep relinks node under read")

endmodule

// ----- rtl/round_robin_task_scheduler.sv -----
// top level of the round-robin task scheduler
`timescale 1ns / 1ps
//
// Takes one action beat on the slave channel (create, start, tick, yield,
// block, wake, kill) and returns exactly one result beat on the master
// channel: result code, current slot, idle flag and the slot of a new task.
// Task state and ring links sit in a one-port-read task table with a
// registered read; the sequencer walks it one slot per cycle.
// Create scans up to the lowest empty slot and, when the ring already
// holds tasks, also closes the ring behind the new tail; tick sweeps
// the whole ring and then searches for the next ready task, unless the
// ring is empty or the scheduler is not started.
// One action is in work at a time; the sequencer returns to idle as the
// result enters the output register. s_tready is high while the
// sequencer is free, also while a finished result waits there.
// After reset all slots are empty, the ring is empty and the scheduler is
// not started. A stalled receiver holds the result in the output register;
// the next action can then run up to its result, where it waits.
//
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // action[2:0], task_slot[6:3]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // status[1:0], current_slot[5:2], new_slot[9:6]
    output logic        o_m_tuser    // running_idle
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    t_tbl_ctl          tbl_ctl;
    logic [SLOT_W-1:0] tbl_raddr;
    logic [SLOT_W-1:0] tbl_st_waddr;
    logic [SLOT_W-1:0] tbl_nx_waddr;
    logic [SLOT_W-1:0] tbl_nx_wdata;
    logic [ST_W-1:0]   tbl_st;
    logic [SLOT_W-1:0] tbl_nx;

    logic  seq_done;
    logic  out_ack;
    t_rslt seq_rslt;

    logic        r_m_valid;
    logic [15:0] r_m_data;
    logic        r_m_user;

    rrts_table #(
        .MAX_TASKS (MAX_TASKS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_raddr    (tbl_raddr),
        .i_st_waddr (tbl_st_waddr),
        .i_nx_waddr (tbl_nx_waddr),
        .i_nx_wdata (tbl_nx_wdata),
        .o_st       (tbl_st),
        .o_nx       (tbl_nx)
    );

    rrts_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_action   (i_s_tdata[2:0]),
        .i_slot     (i_s_tdata[6:3]),
        .o_ctl      (tbl_ctl),
        .o_raddr    (tbl_raddr),
        .o_st_waddr (tbl_st_waddr),
        .o_nx_waddr (tbl_nx_waddr),
        .o_nx_wdata (tbl_nx_wdata),
        .i_st       (tbl_st),
        .i_nx       (tbl_nx),
        .o_done     (seq_done),
        .i_ack      (out_ack),
        .o_rslt     (seq_rslt)
    );

    // output register takes a result when empty or being drained
    assign out_ack = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_ack) begin
            r_m_valid <= seq_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ack && seq_done) begin
            r_m_data <= {6'd0, seq_rslt.new_slot, seq_rslt.cur, seq_rslt.rc};
            r_m_user <= seq_rslt.idle;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

// ----- sim/rrts_checker.sv -----
// scoreboard of the round-robin task scheduler: predicts each result beat and compares it
`timescale 1ns / 1ps

module rrts_checker
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // action[2:0], task_slot[6:3]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // status[1:0], current_slot[5:2], new_slot[9:6]
    input  logic        i_m_tuser,   // running_idle
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // shadow copy of the task table and ring
    logic [ST_W-1:0]      task_state [MAX_TASKS];
    logic [SLOT_IN_W-1:0] link       [MAX_TASKS];
    logic [SLOT_IN_W-1:0] ring_first;
    logic [SLOT_IN_W-1:0] ring_last;
    logic                 ring_used;
    logic [SLOT_IN_W-1:0] cur_slot;
    logic                 is_started;
    logic                 on_idle;

    // results still owed by the block, oldest first
    t_rslt owed_results [$];

    task automatic clear_table();
        for (int i = 0; i < MAX_TASKS; i++) begin
            task_state[i] = SS_EMPTY;
            link[i]       = '0;
        end
        ring_first = '0;
        ring_last  = '0;
        ring_used  = 1'b0;
        cur_slot   = '0;
        is_started = 1'b0;
        on_idle    = 1'b0;
    endtask

    // unlink and free dead tasks, sparing the current one unless idle runs
    task automatic free_dead();
        logic [SLOT_IN_W-1:0] order [MAX_TASKS];
        logic [SLOT_IN_W-1:0] kept  [MAX_TASKS];
        logic [SLOT_IN_W-1:0] s;
        int n;
        int m;
        if (!ring_used) return;
        n = 0;
        m = 0;
        s = ring_first;
        do begin
            order[n] = s;
            n++;
            s = link[s];
        end while (s != ring_first && n < MAX_TASKS);
        for (int i = 0; i < n; i++) begin
            if (task_state[order[i]] == SS_DEAD && (on_idle || order[i] != cur_slot)) begin
                task_state[order[i]] = SS_EMPTY;
            end else begin
                kept[m] = order[i];
                m++;
            end
        end
        if (m == 0) begin
            ring_used  = 1'b0;
            ring_first = '0;
            ring_last  = '0;
            return;
        end
        for (int i = 0; i < m; i++) link[kept[i]] = kept[(i + 1) % m];
        ring_first = kept[0];
        ring_last  = kept[m - 1];
    endtask

    // schedule tick: demote, sweep, then search once round the ring
    task automatic run_tick();
        logic [SLOT_IN_W-1:0] s;
        bit found;
        found = 1'b0;
        if (!on_idle && task_state[cur_slot] == SS_RUNNING) task_state[cur_slot] = SS_READY;
        free_dead();
        if (ring_used) begin
            s = on_idle ? ring_first : link[cur_slot];
            for (int k = 0; k < MAX_TASKS && !found; k++) begin
                if (task_state[s] == SS_READY) begin
                    task_state[s] = SS_RUNNING;
                    cur_slot      = s;
                    on_idle       = 1'b0;
                    found         = 1'b1;
                end else begin
                    s = link[s];
                end
            end
        end
        if (!found) begin
            on_idle  = 1'b1;
            cur_slot = '0;
        end
    endtask

    // apply one action to the shadow state and form its result
    task automatic apply_action(input logic [ACTION_W-1:0] act,
                                input logic [SLOT_IN_W-1:0] slot, output t_rslt r);
        logic [SLOT_IN_W-1:0] pick;
        logic [SLOT_IN_W-1:0] made;
        bit found;
        r.rc  = RC_OK;
        made  = '0;
        pick  = '0;
        found = 1'b0;
        case (act)
            ACT_CREATE: begin
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (!found && task_state[i] == SS_EMPTY) begin
                        found = 1'b1;
                        pick  = i[SLOT_IN_W-1:0];
                    end
                end
                if (!found) begin
                    r.rc = RC_NOFREE;
                end else begin
                    task_state[pick] = SS_READY;
                    if (ring_used) begin
                        link[ring_last] = pick;
                        link[pick]      = ring_first;
                    end else begin
                        ring_first = pick;
                        link[pick] = pick;
                        ring_used  = 1'b1;
                    end
                    ring_last = pick;
                    made      = pick;
                end
            end
            ACT_START: begin
                if (!is_started) begin
                    if (!ring_used) begin
                        r.rc = RC_NOTSTARTED;
                    end else begin
                        is_started           = 1'b1;
                        on_idle              = 1'b0;
                        cur_slot             = ring_first;
                        task_state[cur_slot] = SS_RUNNING;
                    end
                end
            end
            ACT_TICK: begin
                if (!is_started) r.rc = RC_NOTSTARTED;
                else run_tick();
            end
            ACT_YIELD: begin
                if (!is_started) begin
                    r.rc = RC_NOTSTARTED;
                end else if (on_idle) begin
                    if (!ring_used) begin
                        r.rc = RC_NOTSTARTED;
                    end else begin
                        cur_slot = ring_first;
                        on_idle  = 1'b0;
                    end
                end else begin
                    cur_slot = link[cur_slot];
                end
            end
            ACT_BLOCK: begin
                if (!is_started) r.rc = RC_NOTSTARTED;
                else if (!on_idle && task_state[cur_slot] == SS_RUNNING)
                    task_state[cur_slot] = SS_BLOCKED;
            end
            ACT_WAKE: begin
                if (int'(slot) >= MAX_TASKS || task_state[slot] == SS_EMPTY) r.rc = RC_BADSLOT;
                else if (task_state[slot] == SS_BLOCKED) task_state[slot] = SS_READY;
            end
            ACT_KILL: begin
                if (!is_started) r.rc = RC_NOTSTARTED;
                else if (!on_idle) task_state[cur_slot] = SS_DEAD;
            end
            default: ;
        endcase
        r.cur      = on_idle ? '0 : cur_slot;
        r.idle     = on_idle;
        r.new_slot = made;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: result beat %0d, %s: got %0d, expected %0d",
                 $time, o_checked, what, got, want);
        o_fail_count++;
    endtask

    // watch both channels: compare results first, then predict new actions
    always @(posedge i_clk) begin
        t_rslt r;
        if (!i_rst_n) begin
            clear_table();
            owed_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (owed_results.size() == 0) begin
                    report_mismatch("beat with no action outstanding", 1, 0);
                end else begin
                    r = owed_results.pop_front();
                    if (i_m_tdata[1:0] != r.rc)
                        report_mismatch("status", int'(i_m_tdata[1:0]), int'(r.rc));
                    if (i_m_tdata[5:2] != r.cur)
                        report_mismatch("current_slot", int'(i_m_tdata[5:2]), int'(r.cur));
                    if (i_m_tuser != r.idle)
                        report_mismatch("running_idle", int'(i_m_tuser), int'(r.idle));
                    if (i_m_tdata[9:6] != r.new_slot)
                        report_mismatch("new_slot", int'(i_m_tdata[9:6]), int'(r.new_slot));
                    if (i_m_tdata[15:10] != '0)
                        report_mismatch("padding bits", int'(i_m_tdata[15:10]), 0);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_action(i_s_tdata[2:0], i_s_tdata[6:3], r);
                owed_results.push_back(r);
            end
        end
        o_pending = owed_results.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// testbench top of the round-robin task scheduler: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import rrts_pkg::*;

    localparam int MAX_TASKS    = MAX_TASKS_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_TAIL   = 200;
    localparam int PAUSE_AT     = 600;
    localparam int DRAIN_CYCLES = 2 * MAX_TASKS + 16;
    localparam int CYCLE_LIMIT  = 600000;

    // action code with no meaning, answered ok with no change
    localparam logic [ACTION_W-1:0] ACT_UNDEF = 3'd7;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // action[2:0], task_slot[6:3]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // status[1:0], current_slot[5:2], new_slot[9:6]
    logic        o_m_tuser;         // running_idle

    int fail_count;
    int pending;
    int checked;
    int cycles    = 0;
    int sent      = 0;
    int act_seen [8];
    bit quiet     = 1'b0;
    int sink_left = 0;

    round_robin_task_scheduler #(.MAX_TASKS(MAX_TASKS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    rrts_checker #(.MAX_TASKS(MAX_TASKS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result receiver: random ready stretches and stall bursts
    always @(posedge i_clk) begin
        if (quiet) begin
            i_m_tready <= 1'b1;
        end else if (sink_left > 0) begin
            sink_left <= sink_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            sink_left  <= $urandom_range(1, 17) - 1;
        end else begin
            i_m_tready <= 1'b1;
            sink_left  <= $urandom_range(0, 30);
        end
    end

    // one action beat, with an optional gap in front of it
    task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [SLOT_IN_W-1:0] slot);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, slot, act};
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        sent++;
        act_seen[act]++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // random action, weighted toward ticks, creates and wakes
    task automatic send_random();
        int r;
        logic [ACTION_W-1:0] act;
        r = $urandom_range(0, 99);
        if (r < 18)      act = ACT_CREATE;
        else if (r < 21) act = ACT_START;
        else if (r < 46) act = ACT_TICK;
        else if (r < 58) act = ACT_YIELD;
        else if (r < 68) act = ACT_BLOCK;
        else if (r < 83) act = ACT_WAKE;
        else if (r < 96) act = ACT_KILL;
        else             act = ACT_UNDEF;
        send_beat(act, SLOT_IN_W'($urandom_range(0, 15)));
    endtask

    initial begin
        int  k;
        bit  paused;
        foreach (act_seen[i]) act_seen[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // before start: everything but create and the undefined action is refused
        send_beat(ACT_START, 4'd0);
        send_beat(ACT_TICK, 4'd15);
        send_beat(ACT_YIELD, 4'd0);
        send_beat(ACT_BLOCK, 4'd0);
        send_beat(ACT_KILL, 4'd0);
        send_beat(ACT_WAKE, 4'd15);
        send_beat(ACT_WAKE, 4'd0);
        send_beat(ACT_UNDEF, 4'd15);
        send_beat(ACT_CREATE, 4'd0);
        send_beat(ACT_CREATE, 4'd15);
        // wake of a ready task leaves it alone
        send_beat(ACT_WAKE, 4'd1);
        send_beat(ACT_START, 4'd0);
        // second start is ignored
        send_beat(ACT_START, 4'd0);
        send_beat(ACT_BLOCK, 4'd0);
        send_beat(ACT_TICK, 4'd0);
        send_beat(ACT_WAKE, 4'd0);
        send_beat(ACT_KILL, 4'd0);
        // dead current task survives one tick, then is freed
        send_beat(ACT_TICK, 4'd0);
        send_beat(ACT_TICK, 4'd0);
        send_beat(ACT_KILL, 4'd0);
        // nothing ready: idle runs; kill and block are ignored under idle
        send_beat(ACT_TICK, 4'd0);
        send_beat(ACT_KILL, 4'd0);
        send_beat(ACT_BLOCK, 4'd0);
        // tick under idle frees every dead task and empties the ring
        send_beat(ACT_TICK, 4'd0);
        send_beat(ACT_YIELD, 4'd0);

        // random part, with occasional bursts that fill the table past full
        k      = 0;
        paused = 1'b0;
        while (k < RANDOM_ITEMS) begin
            quiet = (k >= RANDOM_ITEMS - QUIET_TAIL);
            if (!paused && k >= PAUSE_AT) begin
                // hold off until every result is back
                paused = 1'b1;
                i_s_tvalid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(0, 39) == 0) begin
                repeat (MAX_TASKS + 1) send_beat(ACT_CREATE, SLOT_IN_W'($urandom_range(0, 15)));
                k += MAX_TASKS + 1;
            end else begin
                send_random();
                k++;
            end
        end
        i_s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d action beats: %0d create, %0d start, %0d tick, %0d yield",
                 sent, act_seen[ACT_CREATE], act_seen[ACT_START], act_seen[ACT_TICK],
                 act_seen[ACT_YIELD]);
        $display("  %0d block, %0d wake, %0d kill, %0d undefined; %0d result beats compared",
                 act_seen[ACT_BLOCK], act_seen[ACT_WAKE], act_seen[ACT_KILL],
                 act_seen[ACT_UNDEF], checked);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_table.sv
rtl/rrts_ctrl.sv
rtl/round_robin_task_scheduler.sv
sim/rrts_checker.sv
sim/tb_top.sv
